// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expect signals named clk and rst_n
// in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALU8_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALU8_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/alu8_pkg.sv =====
// ----------------------------------------------------------------------------
// alu8_pkg
// Operation codes, decoded micro-operation type and constants shared by the
// 8-bit ALU and flags unit.
// ----------------------------------------------------------------------------
package alu8_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Bit positions in the status byte NV-BDIZC.
    localparam int unsigned FLAG_N = 7;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_C = 0;

    typedef enum logic [4:0] {
        OP_ORA = 5'd0,
        OP_AND = 5'd1,
        OP_EOR = 5'd2,
        OP_ADC = 5'd3,
        OP_SBC = 5'd4,
        OP_BIT = 5'd5,
        OP_ASL = 5'd6,
        OP_LSR = 5'd7,
        OP_ROL = 5'd8,
        OP_ROR = 5'd9,
        OP_SLO = 5'd10,
        OP_RLA = 5'd11,
        OP_SRE = 5'd12,
        OP_RRA = 5'd13,
        OP_ANC = 5'd14,
        OP_ALR = 5'd15,
        OP_ARR = 5'd16,
        OP_CLC = 5'd17,
        OP_SEC = 5'd18,
        OP_CLI = 5'd19,
        OP_PLA = 5'd20,
        OP_PLP = 5'd21,
        OP_BRT = 5'd22
    } op_t;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_LOGIC,
        CLS_ADD,
        CLS_BIT,
        CLS_SHIFT,
        CLS_RMW,
        CLS_ANC,
        CLS_ALR,
        CLS_ARR,
        CLS_FLAG,
        CLS_PLA,
        CLS_PLP,
        CLS_BRANCH
    } cls_t;

    typedef enum logic [1:0] {
        LF_OR,
        LF_AND,
        LF_EOR
    } logic_fn_t;

    typedef enum logic [1:0] {
        SF_ASL,
        SF_LSR,
        SF_ROL,
        SF_ROR
    } shift_fn_t;

    typedef enum logic [1:0] {
        FF_CLC,
        FF_SEC,
        FF_CLI
    } flag_fn_t;

    typedef enum logic [1:0] {
        COND_N = 2'd0,
        COND_V = 2'd1,
        COND_C = 2'd2,
        COND_Z = 2'd3
    } cond_t;

    // One classified operation as it travels from the front end to the
    // execute stage.
    typedef struct packed {
        cls_t      cls;
        logic_fn_t logic_fn;
        shift_fn_t shift_fn;
        flag_fn_t  flag_fn;
        logic      invert_operand;
        logic      shift_acc;
        logic      rmw_add;
        logic      mem_write;
        logic [7:0] operand;
        cond_t     cond_flag;
        logic      cond_when_set;
    } uop_t;

endpackage

// ===== rtl/alu8_cmd_if.sv =====
// ----------------------------------------------------------------------------
// alu8_cmd_if
// Operation channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface alu8_cmd_if;

    logic       valid;
    logic       ready;
    logic [4:0] op;
    logic [7:0] operand;
    logic       on_accumulator;
    logic [1:0] cond_flag;
    logic       cond_when_set;

    modport source (
        output valid,
        output op,
        output operand,
        output on_accumulator,
        output cond_flag,
        output cond_when_set,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  operand,
        input  on_accumulator,
        input  cond_flag,
        input  cond_when_set,
        output ready
    );

endinterface

// ===== rtl/alu8_res_if.sv =====
// ----------------------------------------------------------------------------
// alu8_res_if
// Result channel: valid/ready handshake with accumulator, status and
// write-back payload.
// ----------------------------------------------------------------------------
interface alu8_res_if;

    logic       valid;
    logic       ready;
    logic [7:0] acc_out;
    logic [7:0] status_out;
    logic [7:0] mem_value;
    logic       mem_write;
    logic       branch_taken;

    modport source (
        output valid,
        output acc_out,
        output status_out,
        output mem_value,
        output mem_write,
        output branch_taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  acc_out,
        input  status_out,
        input  mem_value,
        input  mem_write,
        input  branch_taken,
        output ready
    );

endinterface

// ===== rtl/alu8_front.sv =====
// ----------------------------------------------------------------------------
// alu8_front
// Accepts operations and classifies them into a micro-operation held in a
// register stage ahead of the queue.
// ----------------------------------------------------------------------------
module alu8_front (
    input  logic              clk,
    input  logic              rst_n,
    alu8_cmd_if.sink          cmd,
    output alu8_pkg::uop_t    uop,
    output logic              uop_valid,
    input  logic              uop_ready
);

    alu8_pkg::uop_t uop_reg;
    alu8_pkg::uop_t uop_next;
    logic           valid_reg;
    logic           take;

    assign cmd.ready = !valid_reg || uop_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        uop_next                = '0;
        uop_next.cls            = alu8_pkg::CLS_NONE;
        uop_next.logic_fn       = alu8_pkg::LF_OR;
        uop_next.shift_fn       = alu8_pkg::SF_ASL;
        uop_next.flag_fn        = alu8_pkg::FF_CLC;
        uop_next.operand        = cmd.operand;
        uop_next.cond_flag      = alu8_pkg::cond_t'(cmd.cond_flag);
        uop_next.cond_when_set  = cmd.cond_when_set;
        case (alu8_pkg::op_t'(cmd.op))
            alu8_pkg::OP_ORA:
            begin
                uop_next.cls      = alu8_pkg::CLS_LOGIC;
                uop_next.logic_fn = alu8_pkg::LF_OR;
            end
            alu8_pkg::OP_AND:
            begin
                uop_next.cls      = alu8_pkg::CLS_LOGIC;
                uop_next.logic_fn = alu8_pkg::LF_AND;
            end
            alu8_pkg::OP_EOR:
            begin
                uop_next.cls      = alu8_pkg::CLS_LOGIC;
                uop_next.logic_fn = alu8_pkg::LF_EOR;
            end
            alu8_pkg::OP_ADC:
            begin
                uop_next.cls = alu8_pkg::CLS_ADD;
            end
            alu8_pkg::OP_SBC:
            begin
                uop_next.cls            = alu8_pkg::CLS_ADD;
                uop_next.invert_operand = 1'b1;
            end
            alu8_pkg::OP_BIT:
            begin
                uop_next.cls = alu8_pkg::CLS_BIT;
            end
            alu8_pkg::OP_ASL, alu8_pkg::OP_LSR, alu8_pkg::OP_ROL, alu8_pkg::OP_ROR:
            begin
                uop_next.cls       = alu8_pkg::CLS_SHIFT;
                uop_next.shift_acc = cmd.on_accumulator;
                uop_next.mem_write = !cmd.on_accumulator;
                case (alu8_pkg::op_t'(cmd.op))
                    alu8_pkg::OP_LSR: uop_next.shift_fn = alu8_pkg::SF_LSR;
                    alu8_pkg::OP_ROL: uop_next.shift_fn = alu8_pkg::SF_ROL;
                    alu8_pkg::OP_ROR: uop_next.shift_fn = alu8_pkg::SF_ROR;
                    default:          uop_next.shift_fn = alu8_pkg::SF_ASL;
                endcase
            end
            alu8_pkg::OP_SLO:
            begin
                uop_next.cls       = alu8_pkg::CLS_RMW;
                uop_next.shift_fn  = alu8_pkg::SF_ASL;
                uop_next.logic_fn  = alu8_pkg::LF_OR;
                uop_next.mem_write = 1'b1;
            end
            alu8_pkg::OP_RLA:
            begin
                uop_next.cls       = alu8_pkg::CLS_RMW;
                uop_next.shift_fn  = alu8_pkg::SF_ROL;
                uop_next.logic_fn  = alu8_pkg::LF_AND;
                uop_next.mem_write = 1'b1;
            end
            alu8_pkg::OP_SRE:
            begin
                uop_next.cls       = alu8_pkg::CLS_RMW;
                uop_next.shift_fn  = alu8_pkg::SF_LSR;
                uop_next.logic_fn  = alu8_pkg::LF_EOR;
                uop_next.mem_write = 1'b1;
            end
            alu8_pkg::OP_RRA:
            begin
                uop_next.cls       = alu8_pkg::CLS_RMW;
                uop_next.shift_fn  = alu8_pkg::SF_ROR;
                uop_next.rmw_add   = 1'b1;
                uop_next.mem_write = 1'b1;
            end
            alu8_pkg::OP_ANC: uop_next.cls = alu8_pkg::CLS_ANC;
            alu8_pkg::OP_ALR: uop_next.cls = alu8_pkg::CLS_ALR;
            alu8_pkg::OP_ARR: uop_next.cls = alu8_pkg::CLS_ARR;
            alu8_pkg::OP_CLC:
            begin
                uop_next.cls     = alu8_pkg::CLS_FLAG;
                uop_next.flag_fn = alu8_pkg::FF_CLC;
            end
            alu8_pkg::OP_SEC:
            begin
                uop_next.cls     = alu8_pkg::CLS_FLAG;
                uop_next.flag_fn = alu8_pkg::FF_SEC;
            end
            alu8_pkg::OP_CLI:
            begin
                uop_next.cls     = alu8_pkg::CLS_FLAG;
                uop_next.flag_fn = alu8_pkg::FF_CLI;
            end
            alu8_pkg::OP_PLA: uop_next.cls = alu8_pkg::CLS_PLA;
            alu8_pkg::OP_PLP: uop_next.cls = alu8_pkg::CLS_PLP;
            alu8_pkg::OP_BRT: uop_next.cls = alu8_pkg::CLS_BRANCH;
            default:          uop_next.cls = alu8_pkg::CLS_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            uop_reg <= uop_next;
        end
    end

    assign uop       = uop_reg;
    assign uop_valid = valid_reg;

endmodule

// ===== rtl/alu8_queue.sv =====
// ----------------------------------------------------------------------------
// alu8_queue
// Short first-in first-out queue of micro-operations between the front end
// and the execute stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alu8_queue #(
    parameter int unsigned DEPTH = alu8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  alu8_pkg::uop_t push_uop,
    input  logic           push_valid,
    output logic           push_ready,
    output alu8_pkg::uop_t pop_uop,
    output logic           pop_valid,
    input  logic           pop_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    alu8_pkg::uop_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_uop    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_uop;
        end
    end

    `ALU8_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_FULL, "queue count beyond depth")
    `ALU8_ASSERT_NXT(a_push_grows, push && !pop, count_reg != '0, "push left queue empty")
    `ALU8_ASSERT_IMP(a_ptr_match, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with pointers apart")

endmodule

// ===== rtl/alu8_back.sv =====
// ----------------------------------------------------------------------------
// alu8_back
// Execute stage: holds the accumulator and status byte, carries out one micro-operation
// per cycle unless the result channel stalls, and registers the result for the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alu8_back (
    input  logic           clk,
    input  logic           rst_n,
    input  alu8_pkg::uop_t uop,
    input  logic           uop_valid,
    output logic           uop_ready,
    alu8_res_if.source     res
);

    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] p_reg;
    logic [7:0] p_next;
    logic       res_valid_reg;
    logic [7:0] mem_value_reg;
    logic [7:0] mem_value_next;
    logic       mem_write_reg;
    logic       mem_write_next;
    logic       taken_reg;
    logic       taken_next;

    logic       pop;
    logic       cin;
    logic [7:0] src;
    logic [7:0] sres;
    logic       sc;
    logic [7:0] lin;
    logic [7:0] lres;
    logic [7:0] addend;
    logic       acin;
    logic [8:0] sum;
    logic       add_v;
    logic [7:0] and_t;
    logic [7:0] arr_res;
    logic       cond_bit;

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r                   = p;
        r[alu8_pkg::FLAG_N] = v[7];
        r[alu8_pkg::FLAG_Z] = (v == 8'h00);
        return r;
    endfunction

    assign uop_ready = !res_valid_reg || res.ready;
    assign pop       = uop_valid && uop_ready;

    always_comb
    begin
        cin = p_reg[alu8_pkg::FLAG_C];
        src = uop.shift_acc ? acc_reg : uop.operand;
        case (uop.shift_fn)
            alu8_pkg::SF_LSR:
            begin
                sres = {1'b0, src[7:1]};
                sc   = src[0];
            end
            alu8_pkg::SF_ROL:
            begin
                sres = {src[6:0], cin};
                sc   = src[7];
            end
            alu8_pkg::SF_ROR:
            begin
                sres = {cin, src[7:1]};
                sc   = src[0];
            end
            default:
            begin
                sres = {src[6:0], 1'b0};
                sc   = src[7];
            end
        endcase

        // Combined operations feed the shifted memory byte into the logic
        // unit and the adder in place of the operand.
        lin = (uop.cls == alu8_pkg::CLS_RMW) ? sres : uop.operand;
        case (uop.logic_fn)
            alu8_pkg::LF_AND: lres = acc_reg & lin;
            alu8_pkg::LF_EOR: lres = acc_reg ^ lin;
            default:          lres = acc_reg | lin;
        endcase

        if (uop.cls == alu8_pkg::CLS_RMW)
        begin
            addend = sres;
            acin   = sc;
        end
        else
        begin
            addend = uop.invert_operand ? ~uop.operand : uop.operand;
            acin   = cin;
        end
        sum   = {1'b0, acc_reg} + {1'b0, addend} + {8'h00, acin};
        add_v = ~(acc_reg[7] ^ addend[7]) & (acc_reg[7] ^ sum[7]);

        and_t   = acc_reg & uop.operand;
        arr_res = {cin, and_t[7:1]};

        case (uop.cond_flag)
            alu8_pkg::COND_N: cond_bit = p_reg[alu8_pkg::FLAG_N];
            alu8_pkg::COND_V: cond_bit = p_reg[alu8_pkg::FLAG_V];
            alu8_pkg::COND_C: cond_bit = p_reg[alu8_pkg::FLAG_C];
            default:          cond_bit = p_reg[alu8_pkg::FLAG_Z];
        endcase

        acc_next       = acc_reg;
        p_next         = p_reg;
        mem_value_next = 8'h00;
        mem_write_next = 1'b0;
        taken_next     = 1'b0;

        case (uop.cls)
            alu8_pkg::CLS_LOGIC:
            begin
                acc_next = lres;
                p_next   = with_nz(p_reg, lres);
            end
            alu8_pkg::CLS_ADD:
            begin
                acc_next                    = sum[7:0];
                p_next                      = with_nz(p_reg, sum[7:0]);
                p_next[alu8_pkg::FLAG_V]    = add_v;
                p_next[alu8_pkg::FLAG_C]    = sum[8];
            end
            alu8_pkg::CLS_BIT:
            begin
                p_next[alu8_pkg::FLAG_N] = uop.operand[7];
                p_next[alu8_pkg::FLAG_V] = uop.operand[6];
                p_next[alu8_pkg::FLAG_Z] = (and_t == 8'h00);
            end
            alu8_pkg::CLS_SHIFT:
            begin
                p_next                   = with_nz(p_reg, sres);
                p_next[alu8_pkg::FLAG_C] = sc;
                if (uop.shift_acc)
                begin
                    acc_next = sres;
                end
                else
                begin
                    mem_value_next = sres;
                    mem_write_next = uop.mem_write;
                end
            end
            alu8_pkg::CLS_RMW:
            begin
                mem_value_next = sres;
                mem_write_next = uop.mem_write;
                if (uop.rmw_add)
                begin
                    acc_next                 = sum[7:0];
                    p_next                   = with_nz(p_reg, sum[7:0]);
                    p_next[alu8_pkg::FLAG_V] = add_v;
                    p_next[alu8_pkg::FLAG_C] = sum[8];
                end
                else
                begin
                    acc_next                 = lres;
                    p_next                   = with_nz(p_reg, lres);
                    p_next[alu8_pkg::FLAG_C] = sc;
                end
            end
            alu8_pkg::CLS_ANC:
            begin
                acc_next                 = and_t;
                p_next                   = with_nz(p_reg, and_t);
                p_next[alu8_pkg::FLAG_C] = and_t[7];
            end
            alu8_pkg::CLS_ALR:
            begin
                acc_next                 = {1'b0, and_t[7:1]};
                p_next                   = with_nz(p_reg, {1'b0, and_t[7:1]});
                p_next[alu8_pkg::FLAG_C] = and_t[0];
            end
            alu8_pkg::CLS_ARR:
            begin
                acc_next                 = arr_res;
                p_next                   = with_nz(p_reg, arr_res);
                p_next[alu8_pkg::FLAG_C] = arr_res[6];
                p_next[alu8_pkg::FLAG_V] = arr_res[6] ^ arr_res[5];
            end
            alu8_pkg::CLS_FLAG:
            begin
                case (uop.flag_fn)
                    alu8_pkg::FF_SEC: p_next[alu8_pkg::FLAG_C] = 1'b1;
                    alu8_pkg::FF_CLI: p_next[alu8_pkg::FLAG_I] = 1'b0;
                    default:          p_next[alu8_pkg::FLAG_C] = 1'b0;
                endcase
            end
            alu8_pkg::CLS_PLA:
            begin
                acc_next = uop.operand;
                p_next   = with_nz(p_reg, uop.operand);
            end
            alu8_pkg::CLS_PLP:
            begin
                p_next = uop.operand;
            end
            alu8_pkg::CLS_BRANCH:
            begin
                taken_next = (cond_bit == uop.cond_when_set);
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'h00;
            p_reg         <= 8'h00;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_reg <= acc_next;
                p_reg   <= p_next;
            end
            if (uop_ready)
            begin
                res_valid_reg <= uop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem_value_reg <= mem_value_next;
            mem_write_reg <= mem_write_next;
            taken_reg     <= taken_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.acc_out      = acc_reg;
    assign res.status_out   = p_reg;
    assign res.mem_value    = mem_value_reg;
    assign res.mem_write    = mem_write_reg;
    assign res.branch_taken = taken_reg;

    `ALU8_ASSERT_NXT(a_pop_shows, pop, res_valid_reg, "executed item not presented")
    `ALU8_ASSERT_NXT(a_hold_state, !uop_ready, $stable({acc_reg, p_reg}), "state moved in stall")
    `ALU8_ASSERT_IMP(a_memv_zero, res_valid_reg && !mem_write_reg, mem_value_reg == 8'h00, "write-back byte without write")

endmodule

// ===== rtl/cpu_8bit_alu_flags_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_8bit_alu_flags_unit
// Binary-mode execute unit of an 8-bit CPU: accumulator, status byte and the
// ALU, split into a classifying front end, a short queue and an execute stage.
//
//   Channel  Direction  Payload
//   cmd      in         op, operand, on_accumulator, cond_flag, cond_when_set
//   res      out        acc_out, status_out, mem_value, mem_write, branch_taken
//
// One item per cycle is sustained while results are taken, dependent items included, as
// the execute stage updates the accumulator and status itself. A result passes through
// the front register, a queue entry and the execute registers before it is shown.
// Reset clears the accumulator, the status byte and all valid state.
// A stalled result holds the execute stage; the queue and front end take items
// until they fill, and the input stays held until the queue count shows a freed entry.
// ----------------------------------------------------------------------------
module cpu_8bit_alu_flags_unit #(
    parameter int unsigned QUEUE_DEPTH = alu8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    alu8_cmd_if.sink   cmd,
    alu8_res_if.source res
);

    alu8_pkg::uop_t front_uop;
    logic           front_valid;
    logic           front_ready;
    alu8_pkg::uop_t queue_uop;
    logic           queue_valid;
    logic           queue_ready;

    alu8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .uop       (front_uop),
        .uop_valid (front_valid),
        .uop_ready (front_ready)
    );

    alu8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_uop   (front_uop),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_uop    (queue_uop),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    alu8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop       (queue_uop),
        .uop_valid (queue_valid),
        .uop_ready (queue_ready),
        .res       (res)
    );

endmodule
